>>> sv/kdbt_pkg.sv
package kdbt_pkg;

	localparam int DEPTH = 16;
	localparam int IDX_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);

	localparam logic [2:0] REQ_PUSH_BACK  = 3'd0;
	localparam logic [2:0] REQ_PUSH_FRONT = 3'd1;
	localparam logic [2:0] REQ_POP_BACK   = 3'd2;
	localparam logic [2:0] REQ_POP_FRONT  = 3'd3;
	localparam logic [2:0] REQ_ADD        = 3'd4;
	localparam logic [2:0] REQ_LOOKUP     = 3'd5;

	typedef struct packed {
		logic [2:0]         req_type;
		logic signed [31:0] key;
		logic signed [31:0] amount;
	} kdbt_req_t;

	typedef struct packed {
		logic               ok;
		logic signed [31:0] out_key;
		logic signed [31:0] out_balance;
		logic [CNT_W-1:0]   entry_count;
	} kdbt_res_t;

	typedef struct packed {
		logic signed [31:0] key;
		logic signed [31:0] balance;
	} kdbt_rec_t;

	typedef struct packed {
		logic             we_key;
		logic             we_bal;
		logic [IDX_W-1:0] waddr;
		kdbt_rec_t        wdata;
		logic             re;
		logic [IDX_W-1:0] raddr;
	} kdbt_mem_cmd_t;

	// Saturating signed 32-bit add.
	function automatic logic signed [31:0] sat_add(input logic signed [31:0] a,
			input logic signed [31:0] b);
		logic [32:0] s;
		s = {a[31], a} + {b[31], b};
		if (s[32] != s[31]) begin
			sat_add = s[32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
		end else begin
			sat_add = s[31:0];
		end
	endfunction

	// Ring slot of the record at a given position from the front.
	function automatic logic [IDX_W-1:0] slot_of(input logic [IDX_W-1:0] front,
			input logic [CNT_W-1:0] pos);
		logic [CNT_W:0] sum;
		sum = {{(CNT_W + 1 - IDX_W){1'b0}}, front} + {1'b0, pos};
		if (sum >= (CNT_W + 1)'(DEPTH)) begin
			sum = sum - (CNT_W + 1)'(DEPTH);
		end
		slot_of = sum[IDX_W-1:0];
	endfunction

endpackage

>>> sv/keyed_deque_balance_table_unit.sv
// Pushes, unknown commands and pops of an empty table answer from the execute state;
// other pops read the record there and answer from the pop state. Add and lookup scan
// from the front, one record per cycle through the memory read port, and stop at the
// first matching key or after the last record; on an empty table they do not scan.
// One command at a time; busy is low again in the cycle the result strobe is high.
// Reset clears the front pointer and the record count; the record memory is not cleared.
module keyed_deque_balance_table_unit
	import kdbt_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      start,
	input  kdbt_req_t req,
	output logic      busy,
	output logic      done,
	output kdbt_res_t res
);

	kdbt_mem_cmd_t mem_cmd;
	kdbt_rec_t     mem_rdata;

	kdbt_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.req       (req),
		.busy      (busy),
		.done      (done),
		.res       (res),
		.mem_cmd   (mem_cmd),
		.mem_rdata (mem_rdata)
	);

	kdbt_mem u_mem (
		.clk   (clk),
		.cmd   (mem_cmd),
		.rdata (mem_rdata)
	);

`ifndef SYNTHESIS
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy && !done)
		else $error("accepted word did not make the unit busy");

	a_done_ends_busy: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(busy) |-> done)
		else $error("unit went idle without a result word");

	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done && !res.ok |-> res.out_key == 0 && res.out_balance == 0)
		else $error("failed command returned a non-zero record");

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> res.entry_count <= CNT_W'(DEPTH))
		else $error("record count beyond the table depth");
`endif

endmodule

>>> sv/kdbt_mem.sv
module kdbt_mem
	import kdbt_pkg::*;
(
	input  logic          clk,
	input  kdbt_mem_cmd_t cmd,
	output kdbt_rec_t     rdata
);

	logic signed [31:0] keys [DEPTH];
	logic signed [31:0] bals [DEPTH];

	always_ff @(posedge clk) begin
		if (cmd.we_key) begin
			keys[cmd.waddr] <= cmd.wdata.key;
		end
		if (cmd.we_bal) begin
			bals[cmd.waddr] <= cmd.wdata.balance;
		end
		if (cmd.re) begin
			rdata.key     <= keys[cmd.raddr];
			rdata.balance <= bals[cmd.raddr];
		end
	end

endmodule

>>> sv/kdbt_ctrl.sv
module kdbt_ctrl
	import kdbt_pkg::*;
(
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  kdbt_req_t     req,
	output logic          busy,
	output logic          done,
	output kdbt_res_t     res,
	output kdbt_mem_cmd_t mem_cmd,
	input  kdbt_rec_t     mem_rdata
);

	typedef enum logic [3:0] {
		S_IDLE = 4'b0001,
		S_EXEC = 4'b0010,
		S_POP  = 4'b0100,
		S_SCAN = 4'b1000
	} state_t;

	state_t           state_q, state_d;
	kdbt_req_t        req_q;
	logic [IDX_W-1:0] front_q, front_d;
	logic [CNT_W-1:0] count_q, count_d;
	logic [CNT_W-1:0] pos_q, pos_d;
	logic             done_q, done_d;
	kdbt_res_t        res_q, res_d;
	logic [CNT_W-1:0] pos_nxt;
	logic signed [31:0] new_bal;

	assign pos_nxt = pos_q + 1'b1;
	assign new_bal = sat_add(mem_rdata.balance, req_q.amount);

	always_comb begin
		state_d = state_q;
		front_d = front_q;
		count_d = count_q;
		pos_d   = pos_q;
		done_d  = 1'b0;
		res_d   = '0;
		mem_cmd = '0;
		mem_cmd.wdata.key     = req_q.key;
		mem_cmd.wdata.balance = req_q.amount;
		case (state_q)
			S_IDLE: begin
				if (start) begin
					state_d = S_EXEC;
				end
			end
			S_EXEC: begin
				state_d = S_IDLE;
				done_d  = 1'b1;
				res_d.entry_count = count_q;
				case (req_q.req_type)
					REQ_PUSH_BACK, REQ_PUSH_FRONT: begin
						if (count_q < CNT_W'(DEPTH)) begin
							mem_cmd.we_key = 1'b1;
							mem_cmd.we_bal = 1'b1;
							if (req_q.req_type == REQ_PUSH_BACK) begin
								mem_cmd.waddr = slot_of(front_q, count_q);
							end else begin
								front_d = (front_q == '0) ? IDX_W'(DEPTH - 1)
									: front_q - 1'b1;
								mem_cmd.waddr = front_d;
							end
							count_d = count_q + 1'b1;
							res_d.ok = 1'b1;
							res_d.entry_count = count_d;
						end
					end
					REQ_POP_BACK, REQ_POP_FRONT: begin
						if (count_q != '0) begin
							mem_cmd.re = 1'b1;
							if (req_q.req_type == REQ_POP_BACK) begin
								mem_cmd.raddr = slot_of(front_q, count_q - 1'b1);
							end else begin
								mem_cmd.raddr = front_q;
								front_d = (front_q == IDX_W'(DEPTH - 1)) ? '0
									: front_q + 1'b1;
							end
							count_d = count_q - 1'b1;
							state_d = S_POP;
							done_d  = 1'b0;
						end
					end
					REQ_ADD, REQ_LOOKUP: begin
						if (count_q != '0) begin
							mem_cmd.re    = 1'b1;
							mem_cmd.raddr = front_q;
							pos_d   = '0;
							state_d = S_SCAN;
							done_d  = 1'b0;
						end
					end
					default: begin
					end
				endcase
			end
			S_POP: begin
				state_d = S_IDLE;
				done_d  = 1'b1;
				res_d.ok          = 1'b1;
				res_d.out_key     = mem_rdata.key;
				res_d.out_balance = mem_rdata.balance;
				res_d.entry_count = count_q;
			end
			S_SCAN: begin
				res_d.entry_count = count_q;
				if (mem_rdata.key == req_q.key) begin
					state_d = S_IDLE;
					done_d  = 1'b1;
					res_d.ok      = 1'b1;
					res_d.out_key = mem_rdata.key;
					if (req_q.req_type == REQ_ADD) begin
						mem_cmd.we_bal        = 1'b1;
						mem_cmd.waddr         = slot_of(front_q, pos_q);
						mem_cmd.wdata.balance = new_bal;
						res_d.out_balance     = new_bal;
					end else begin
						res_d.out_balance = mem_rdata.balance;
					end
				end else if (pos_nxt == count_q) begin
					state_d = S_IDLE;
					done_d  = 1'b1;
				end else begin
					// Read the next record while this one is being compared.
					mem_cmd.re    = 1'b1;
					mem_cmd.raddr = slot_of(front_q, pos_nxt);
					pos_d = pos_nxt;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			front_q <= '0;
			count_q <= '0;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			front_q <= front_d;
			count_q <= count_d;
			done_q  <= done_d;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && start) begin
			req_q <= req;
		end
		pos_q <= pos_d;
		res_q <= res_d;
	end

	assign busy = (state_q != S_IDLE);
	assign done = done_q;
	assign res  = res_q;

endmodule

>>> bench/tb_keyed_deque_balance_table_unit.sv
`timescale 1ns / 1ps

module tb_keyed_deque_balance_table_unit;
	import kdbt_pkg::*;

	localparam logic [2:0] REQ_SPARE_6 = 3'd6;
	localparam logic [2:0] REQ_SPARE_7 = 3'd7;
	localparam int RANDOM_WORDS = 900;
	localparam int CYCLE_LIMIT = 400000;
	localparam int TAIL_CYCLES = DEPTH + 4;
	localparam int MAX_PRINTED = 40;
	localparam longint BAL_MAX = 64'sd2147483647;
	localparam longint BAL_MIN = -64'sd2147483648;

	typedef struct {
		kdbt_req_t word;
		int        reps;
		bit        typed;
		kdbt_res_t want;
	} dir_row_t;

	logic      clk;
	logic      arst_n;
	logic      start;
	kdbt_req_t req;
	logic      busy;
	logic      done;
	kdbt_res_t res;

	// Shadow copy of the ring: keys, balances, front slot and occupancy.
	logic signed [31:0] sh_key [DEPTH];
	logic signed [31:0] sh_bal [DEPTH];
	logic [IDX_W-1:0]   sh_front;
	logic [CNT_W-1:0]   sh_count;

	kdbt_res_t          due_replies[$];
	dir_row_t           dir_rows[$];
	logic signed [31:0] key_pool [8];
	bit                 filling;
	int                 burst_left;
	int                 errors;
	int                 replies_seen;
	int                 cycles;

	keyed_deque_balance_table_unit u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.req    (req),
		.busy   (busy),
		.done   (done),
		.res    (res)
	);

	initial clk = 1'b0;
	always #6 clk = ~clk;

	function automatic int ring_slot(input int pos);
		ring_slot = (int'(sh_front) + pos) % DEPTH;
	endfunction

	function automatic kdbt_res_t deque_step(input kdbt_req_t w);
		kdbt_res_t r;
		int        s;
		int        hit;
		longint    sum;
		r = '0;
		case (w.req_type)
			REQ_PUSH_BACK, REQ_PUSH_FRONT: begin
				if (sh_count < DEPTH) begin
					if (w.req_type == REQ_PUSH_BACK) begin
						s = ring_slot(int'(sh_count));
					end else begin
						sh_front = IDX_W'((int'(sh_front) + DEPTH - 1) % DEPTH);
						s = int'(sh_front);
					end
					sh_key[s] = w.key;
					sh_bal[s] = w.amount;
					sh_count = sh_count + 1'b1;
					r.ok = 1'b1;
				end
			end
			REQ_POP_BACK, REQ_POP_FRONT: begin
				if (sh_count != 0) begin
					s = (w.req_type == REQ_POP_BACK) ? ring_slot(int'(sh_count) - 1)
						: int'(sh_front);
					r.out_key = sh_key[s];
					r.out_balance = sh_bal[s];
					if (w.req_type == REQ_POP_FRONT) begin
						sh_front = IDX_W'((int'(sh_front) + 1) % DEPTH);
					end
					sh_count = sh_count - 1'b1;
					r.ok = 1'b1;
				end
			end
			REQ_ADD, REQ_LOOKUP: begin
				hit = -1;
				for (int i = 0; i < int'(sh_count); i++) begin
					if (hit < 0 && sh_key[ring_slot(i)] == w.key) begin
						hit = i;
					end
				end
				if (hit >= 0) begin
					s = ring_slot(hit);
					if (w.req_type == REQ_ADD) begin
						sum = longint'($signed(sh_bal[s])) + longint'($signed(w.amount));
						if (sum > BAL_MAX) begin
							sum = BAL_MAX;
						end else if (sum < BAL_MIN) begin
							sum = BAL_MIN;
						end
						sh_bal[s] = sum[31:0];
					end
					r.out_key = sh_key[s];
					r.out_balance = sh_bal[s];
					r.ok = 1'b1;
				end
			end
			default: begin
			end
		endcase
		r.entry_count = sh_count;
		deque_step = r;
	endfunction

	function automatic dir_row_t dir_row(input logic [2:0] op, input logic [31:0] k,
			input logic [31:0] a, input int reps, input int typed, input int okv,
			input logic [31:0] ek, input logic [31:0] eb, input int ec);
		dir_row_t d;
		d.word.req_type = op;
		d.word.key = k;
		d.word.amount = a;
		d.reps = reps;
		d.typed = (typed != 0);
		d.want.ok = (okv != 0);
		d.want.out_key = ek;
		d.want.out_balance = eb;
		d.want.entry_count = CNT_W'(ec);
		dir_row = d;
	endfunction

	// Mostly keys from a small pool so that adds and lookups hit, with extremes in the pool.
	function automatic kdbt_req_t random_word();
		kdbt_req_t w;
		int        r;
		int        push_pct;
		int        pop_pct;
		r = $urandom_range(0, 99);
		push_pct = filling ? 50 : 15;
		pop_pct = filling ? 15 : 45;
		if (r < 3) begin
			w.req_type = $urandom_range(0, 1) ? REQ_SPARE_6 : REQ_SPARE_7;
		end else if (r < 3 + push_pct) begin
			w.req_type = $urandom_range(0, 1) ? REQ_PUSH_FRONT : REQ_PUSH_BACK;
		end else if (r < 3 + push_pct + pop_pct) begin
			w.req_type = $urandom_range(0, 1) ? REQ_POP_FRONT : REQ_POP_BACK;
		end else begin
			w.req_type = $urandom_range(0, 1) ? REQ_LOOKUP : REQ_ADD;
		end
		w.key = ($urandom_range(0, 9) == 0) ? $urandom : key_pool[$urandom_range(0, 7)];
		case ($urandom_range(0, 7))
			0: w.amount = 32'h7FFF_FFFF - $urandom_range(0, 255);
			1: w.amount = 32'h8000_0000 + $urandom_range(0, 255);
			2: w.amount = $urandom_range(0, 4095) - 2048;
			default: w.amount = $urandom;
		endcase
		random_word = w;
	endfunction

	task automatic report_mismatch(input string what, input logic [31:0] got,
			input logic [31:0] want);
		errors++;
		if (errors <= MAX_PRINTED) begin
			$display("%0t: reply %0d %s got %h want %h", $time, replies_seen, what, got, want);
		end
	endtask

	task automatic check_reply(input kdbt_res_t got);
		kdbt_res_t want;
		if (due_replies.size() == 0) begin
			report_mismatch("unexpected", 32'(got.ok), 32'h0);
		end else begin
			want = due_replies.pop_front();
			if (got.ok !== want.ok) report_mismatch("ok", 32'(got.ok), 32'(want.ok));
			if (got.out_key !== want.out_key) report_mismatch("out_key", got.out_key, want.out_key);
			if (got.out_balance !== want.out_balance) begin
				report_mismatch("out_balance", got.out_balance, want.out_balance);
			end
			if (got.entry_count !== want.entry_count) begin
				report_mismatch("entry_count", 32'(got.entry_count), 32'(want.entry_count));
			end
		end
		replies_seen++;
	endtask

	// Called at a rising edge; returns at the edge that accepts the word.
	task automatic send_word(input kdbt_req_t w, input bit typed, input kdbt_res_t want);
		int        gap;
		kdbt_res_t model;
		gap = 0;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
			burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(30, 60)
				: $urandom_range(1, 8);
		end
		burst_left--;
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start <= 1'b1;
		req <= w;
		do @(posedge clk); while (busy);
		model = deque_step(w);
		due_replies.push_back(typed ? want : model);
	endtask

	always @(posedge clk) begin
		if (arst_n && done) begin
			check_reply(res);
		end
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("tb: failure");
			$finish;
		end
	end

	initial begin
		int mode_left;
		arst_n = 1'b0;
		start = 1'b0;
		req = '0;
		errors = 0;
		replies_seen = 0;
		cycles = 0;
		burst_left = 0;
		filling = 1'b1;
		mode_left = $urandom_range(20, 80);
		sh_front = '0;
		sh_count = '0;
		for (int i = 0; i < DEPTH; i++) begin
			sh_key[i] = '0;
			sh_bal[i] = '0;
		end
		key_pool[0] = 32'h8000_0000;
		key_pool[1] = 32'h7FFF_FFFF;
		key_pool[2] = 32'h0;
		key_pool[3] = 32'hFFFF_FFFF;
		for (int i = 4; i < 8; i++) key_pool[i] = $urandom;

		// Empty table, unused codes, extremes and saturation, then a full table.
		dir_rows.push_back(dir_row(REQ_POP_BACK, 32'h0, 32'h0, 1, 1, 0, 0, 0, 0));
		dir_rows.push_back(dir_row(REQ_POP_FRONT, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1, 1, 0, 0, 0, 0));
		dir_rows.push_back(dir_row(REQ_ADD, 32'h5, 32'h1, 1, 1, 0, 0, 0, 0));
		dir_rows.push_back(dir_row(REQ_LOOKUP, 32'h5, 32'h0, 1, 1, 0, 0, 0, 0));
		dir_rows.push_back(dir_row(REQ_SPARE_6, 32'h0, 32'h0, 1, 1, 0, 0, 0, 0));
		dir_rows.push_back(dir_row(REQ_SPARE_7, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1, 1, 0, 0, 0, 0));
		dir_rows.push_back(dir_row(REQ_PUSH_BACK, 32'h7FFF_FFFF, 32'h7FFF_FF00, 1, 1,
			1, 0, 0, 1));
		dir_rows.push_back(dir_row(REQ_PUSH_FRONT, 32'h8000_0000, 32'h8000_0000, 1, 1,
			1, 0, 0, 2));
		dir_rows.push_back(dir_row(REQ_ADD, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1, 1,
			1, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 2));
		dir_rows.push_back(dir_row(REQ_ADD, 32'h8000_0000, 32'h8000_0000, 1, 1,
			1, 32'h8000_0000, 32'h8000_0000, 2));
		dir_rows.push_back(dir_row(REQ_LOOKUP, 32'h0, 32'h0, 1, 1, 0, 0, 0, 2));
		dir_rows.push_back(dir_row(REQ_LOOKUP, 32'h7FFF_FFFF, 32'h0, 1, 0, 0, 0, 0, 0));
		dir_rows.push_back(dir_row(REQ_POP_FRONT, 32'h0, 32'h0, 1, 1,
			1, 32'h8000_0000, 32'h8000_0000, 1));
		dir_rows.push_back(dir_row(REQ_POP_BACK, 32'h0, 32'h0, 1, 1,
			1, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 0));
		dir_rows.push_back(dir_row(REQ_POP_BACK, 32'h0, 32'h0, 1, 1, 0, 0, 0, 0));
		dir_rows.push_back(dir_row(REQ_PUSH_BACK, 32'h3, 32'h64, 8, 0, 0, 0, 0, 0));
		dir_rows.push_back(dir_row(REQ_PUSH_FRONT, 32'h3, 32'hFFFF_FF00, 8, 0, 0, 0, 0, 0));
		dir_rows.push_back(dir_row(REQ_PUSH_BACK, 32'h9, 32'h1, 1, 1, 0, 0, 0, DEPTH));
		dir_rows.push_back(dir_row(REQ_PUSH_FRONT, 32'h9, 32'h1, 1, 1, 0, 0, 0, DEPTH));
		dir_rows.push_back(dir_row(REQ_LOOKUP, 32'h3, 32'h0, 1, 0, 0, 0, 0, 0));
		dir_rows.push_back(dir_row(REQ_ADD, 32'h3, 32'h180, 1, 0, 0, 0, 0, 0));
		dir_rows.push_back(dir_row(REQ_LOOKUP, 32'h9, 32'h0, 1, 1, 0, 0, 0, DEPTH));
		dir_rows.push_back(dir_row(REQ_POP_BACK, 32'h0, 32'h0, 1, 0, 0, 0, 0, 0));
		dir_rows.push_back(dir_row(REQ_POP_FRONT, 32'h0, 32'h0, 1, 0, 0, 0, 0, 0));

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (dir_rows[i]) begin
			for (int r = 0; r < dir_rows[i].reps; r++) begin
				send_word(dir_rows[i].word, dir_rows[i].typed, dir_rows[i].want);
			end
		end

		// Swing between filling and draining so that both the full and the empty table recur.
		for (int n = 0; n < RANDOM_WORDS; n++) begin
			if (mode_left == 0) begin
				filling = !filling;
				mode_left = $urandom_range(20, 80);
				key_pool[$urandom_range(4, 7)] = $urandom;
			end
			mode_left--;
			send_word(random_word(), 1'b0, '0);
		end
		start <= 1'b0;

		while (due_replies.size() != 0) @(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);
		if (errors == 0) begin
			$display("tb: success");
		end else begin
			$display("tb: failure");
		end
		$finish;
	end

endmodule
